@@ rtl/bfgr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bfgr_pkg;

  localparam int unsigned GlyphRows  = 6;
  localparam int unsigned NarrowW    = 3;
  localparam int unsigned WideW      = 5;
  localparam int unsigned GlyphBits  = GlyphRows * WideW;
  localparam int unsigned GlyphCount = 36;
  localparam int unsigned IdxW       = $clog2(GlyphCount);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharZ     = 8'h5A;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [IdxW-1:0] IdxM     = IdxW'(12);
  localparam logic [IdxW-1:0] IdxW_    = IdxW'(22);
  localparam logic [IdxW-1:0] IdxDigit = IdxW'(26);

  localparam logic [15:0] AdvSpace  = 16'd3;
  localparam logic [15:0] AdvBad    = 16'd4;
  localparam logic [15:0] AdvNarrow = 16'(NarrowW + 1);
  localparam logic [15:0] AdvWide   = 16'(WideW + 1);

  localparam logic CmdStart = 1'b0;
  localparam logic CmdChar  = 1'b1;

  typedef struct packed {
    logic load_start;
    logic load_char;
    logic step;
  } bfgr_cmd_t;

  typedef struct packed {
    logic char_lit;
    logic scan_last;
    logic out_free;
  } bfgr_stat_t;

  function automatic logic [GlyphBits-1:0] glyph_rom(input logic [IdxW-1:0] idx);
    logic [GlyphBits-1:0] g;
    unique case (idx)
      6'd0:  g = 30'h1DF6D;
      6'd1:  g = 30'h35F6F;
      6'd2:  g = 30'h1C927;
      6'd3:  g = 30'h35B6E;
      6'd4:  g = 30'h3CD27;
      6'd5:  g = 30'h1CD24;
      6'd6:  g = 30'h1C96F;
      6'd7:  g = 30'h2DF6D;
      6'd8:  g = 30'h3A497;
      6'd9:  g = 30'h3924E;
      6'd10: g = 30'h2DD6D;
      6'd11: g = 30'h24927;
      6'd12: g = 30'h3D5AD6B1;
      6'd13: g = 30'h35B6D;
      6'd14: g = 30'h1DB6E;
      6'd15: g = 30'h3DD24;
      6'd16: g = 30'h1DB71;
      6'd17: g = 30'h3DD6D;
      6'd18: g = 30'h1CE4E;
      6'd19: g = 30'h3A492;
      6'd20: g = 30'h2DB6F;
      6'd21: g = 30'h2DB6A;
      6'd22: g = 30'h235AD6AA;
      6'd23: g = 30'h2D4AD;
      6'd24: g = 30'h2DA92;
      6'd25: g = 30'h394A7;
      6'd26: g = 30'h1DB6E;
      6'd27: g = 30'h16497;
      6'd28: g = 30'h312A7;
      6'd29: g = 30'h31C4E;
      6'd30: g = 30'h2D649;
      6'd31: g = 30'h3CC4E;
      6'd32: g = 30'h1CD6B;
      6'd33: g = 30'h39292;
      6'd34: g = 30'h1D56E;
      6'd35: g = 30'h35ACE;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Reorder row-major glyph bits into scan order: column j, then row k.
  function automatic logic [GlyphBits-1:0] col_major(input logic [GlyphBits-1:0] g,
                                                      input logic wide);
    logic [GlyphBits-1:0] cm;
    cm = '0;
    for (int j = 0; j < WideW; j++) begin
      for (int k = 0; k < GlyphRows; k++) begin
        if (wide) begin
          cm[j*GlyphRows+k] = g[k*WideW+j];
        end else if (j < NarrowW) begin
          cm[j*GlyphRows+k] = g[k*NarrowW+j];
        end
      end
    end
    return cm;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bfgr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bfgr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                cmd_i,
  input  wire bfgr_pkg::bfgr_stat_t stat_i,
  output bfgr_pkg::bfgr_cmd_t      cmd_o
);
  import bfgr_pkg::*;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load_start = accept && (cmd_i == CmdStart);
    cmd_o.load_char  = accept && (cmd_i == CmdChar);
    cmd_o.step       = (state_q == StScan) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.load_char && stat_i.char_lit) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (cmd_o.step && stat_i.scan_last) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_no_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !cmd_o.step)
    else $error("step issued while idle");
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && stat_i.scan_last) |=> (state_q == StIdle))
    else $error("scan did not finish");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_start) |=> (state_q == StIdle))
    else $error("start item left idle");

endmodule
`default_nettype wire

@@ rtl/bfgr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bfgr_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bfgr_pkg::bfgr_cmd_t  cmd_i,
  output bfgr_pkg::bfgr_stat_t      stat_o,
  input  wire logic [15:0]          origin_x_i,
  input  wire logic [15:0]          origin_y_i,
  input  wire logic [23:0]          color_i,
  input  wire logic [7:0]           char_code_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [15:0]               pixel_x_o,
  output logic [15:0]               pixel_y_o,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o,
  output logic                      last_o
);
  import bfgr_pkg::*;

  localparam int unsigned RowW = $clog2(GlyphRows);

  logic [15:0]          cursor_x_q, cursor_y_q;
  logic [23:0]          color_q;
  logic [GlyphBits-1:0] scan_q;
  logic [15:0]          x_q, y_q, y_top_q;
  logic [RowW-1:0]      row_q;

  logic                 out_valid_q, out_last_q;
  logic [15:0]          out_x_q, out_y_q;
  logic [23:0]          out_color_q;

  // Character decode
  logic                 is_space, is_alpha, is_digit, wide;
  logic [IdxW-1:0]      idx;
  logic [GlyphBits-1:0] scan_d;
  logic [15:0]          adv, width16;

  always_comb begin
    is_space = (char_code_i == CharSpace);
    is_alpha = (char_code_i >= CharA) && (char_code_i <= CharZ);
    is_digit = (char_code_i >= Char0) && (char_code_i <= Char9);
    idx      = '0;
    if (is_alpha) begin
      idx = IdxW'(char_code_i - CharA);
    end else if (is_digit) begin
      idx = IdxW'(char_code_i - Char0) + IdxDigit;
    end
    wide    = is_alpha && ((idx == IdxM) || (idx == IdxW_));
    width16 = wide ? 16'(WideW) : 16'(NarrowW);
    scan_d  = (is_alpha || is_digit) ? col_major(glyph_rom(idx), wide) : '0;
    priority if (is_space) begin
      adv = AdvSpace;
    end else if (is_alpha || is_digit) begin
      adv = wide ? AdvWide : AdvNarrow;
    end else begin
      adv = AdvBad;
    end
  end

  logic row_wrap, emit;
  assign row_wrap = (row_q == RowW'(GlyphRows - 1));
  assign emit     = cmd_i.step && scan_q[0];

  always_comb begin
    stat_o.char_lit  = (scan_d != '0);
    stat_o.scan_last = (scan_q[GlyphBits-1:1] == '0);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      color_q    <= '0;
      scan_q     <= '0;
      row_q      <= '0;
    end else begin
      if (cmd_i.load_start) begin
        cursor_x_q <= origin_x_i;
        cursor_y_q <= origin_y_i;
        color_q    <= color_i;
      end else if (cmd_i.load_char) begin
        cursor_x_q <= cursor_x_q + adv;
        scan_q     <= scan_d;
        row_q      <= '0;
      end else if (cmd_i.step) begin
        scan_q <= scan_q >> 1;
        row_q  <= row_wrap ? '0 : row_q + 1'b1;
      end
    end
  end

  // Pixel coordinates track the scan: x per column, y per row.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) begin
      x_q     <= cursor_x_q + width16;
      y_q     <= cursor_y_q + 16'(GlyphRows - 1);
      y_top_q <= cursor_y_q + 16'(GlyphRows - 1);
    end else if (cmd_i.step) begin
      if (row_wrap) begin
        x_q <= x_q - 16'd1;
        y_q <= y_top_q;
      end else begin
        y_q <= y_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= x_q;
      out_y_q     <= y_q;
      out_color_q <= color_q;
      out_last_q  <= stat_o.scan_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign red_o       = out_color_q[23:16];
  assign green_o     = out_color_q[15:8];
  assign blue_o      = out_color_q[7:0];
  assign last_o      = out_last_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("pending pixel overwritten");
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && stat_o.scan_last) |=> (scan_q == '0))
    else $error("bits left after last pixel");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= RowW'(GlyphRows - 1))
    else $error("row counter out of range");

endmodule
`default_nettype wire

@@ rtl/bitmap_font_glyph_rasterizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// The first pixel of a character follows its acceptance through the scan register and the
// pixel output register, after one scan step for each unlit glyph position scanned before it.
// A start, space or unsupported item needs no scan; a glyph takes one scan step per glyph
// position up to its last lit pixel (at most 18, or 30 for M and W), each step waiting
// while the pixel output register is full; no new item is taken until the scan is done.
// Reset clears cursor, color, scan state and output valid.
module bitmap_font_glyph_rasterizer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] origin_x_i,
  input  wire logic [15:0] origin_y_i,
  input  wire logic [23:0] color_i,
  input  wire logic [7:0]  char_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      pixel_x_o,
  output logic [15:0]      pixel_y_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             last_o
);
  import bfgr_pkg::*;

  bfgr_cmd_t  ctl_cmd;
  bfgr_stat_t dp_stat;

  bfgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  bfgr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .color_i     (color_i),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import bfgr_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [23:0] col;
    logic [7:0]  ch;
    logic        quiet;  // typed expectation: the item draws nothing
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = 1'b0;
  logic [15:0] origin_x_i  = '0;
  logic [15:0] origin_y_i  = '0;
  logic [23:0] color_i     = '0;
  logic [7:0]  char_code_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] pixel_x_o;
  logic [15:0] pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        last_o;

  bitmap_font_glyph_rasterizer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .color_i     (color_i),
    .char_code_i (char_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_o      (last_o)
  );

  // Font bitmaps, row-major: bit k*width+j is row k, column j.
  logic [29:0] font_rom [36];

  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [23:0] pen_color;

  pixel_t      pixels_due [$];
  int unsigned items_in   = 0;
  int unsigned mismatches = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Update the pen and, when draw is set, queue the pixels this item lights.
  task automatic rasterize_item(input logic c, input logic [15:0] ox, input logic [15:0] oy,
                                input logic [23:0] col, input logic [7:0] ch, input bit draw);
    int unsigned idx;
    int unsigned wd;
    int unsigned lit;
    logic [29:0] bits;
    pixel_t      px;
    lit = 0;
    if (c == CmdStart) begin
      pen_x     = ox;
      pen_y     = oy;
      pen_color = col;
    end else if (ch == CharSpace) begin
      pen_x = pen_x + AdvSpace;
    end else if (!((ch >= CharA && ch <= CharZ) || (ch >= Char0 && ch <= Char9))) begin
      pen_x = pen_x + AdvBad;
    end else begin
      idx  = (ch >= CharA) ? int'(ch - CharA) : int'(IdxDigit) + int'(ch - Char0);
      wd   = (idx == IdxM || idx == IdxW_) ? WideW : NarrowW;
      bits = font_rom[idx];
      for (int j = 0; j < wd; j++) begin
        for (int k = 0; k < GlyphRows; k++) begin
          if (bits[k*wd+j]) begin
            px.x    = pen_x + 16'(wd - j);
            px.y    = pen_y + 16'(GlyphRows - 1 - k);
            px.r    = pen_color[23:16];
            px.g    = pen_color[15:8];
            px.b    = pen_color[7:0];
            px.last = 1'b0;
            if (draw) pixels_due.push_back(px);
            lit++;
          end
        end
      end
      if (draw && lit != 0) pixels_due[pixels_due.size()-1].last = 1'b1;
      pen_x = pen_x + ((wd == WideW) ? AdvWide : AdvNarrow);
    end
  endtask

  // Offer one item, with random idle cycles first outside items 200 to 279, and hold it until accepted.
  task automatic send_item(input logic c, input logic [15:0] ox, input logic [15:0] oy,
                           input logic [23:0] col, input logic [7:0] ch, input bit quiet);
    while ((items_in < 200 || items_in >= 280) && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    origin_x_i  <= ox;
    origin_y_i  <= oy;
    color_i     <= col;
    char_code_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    rasterize_item(c, ox, oy, col, ch, !quiet);
    items_in <= items_in + 1;
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    mismatches++;
  endtask

  initial begin : sink
    int unsigned hold_left;
    bit          held_once;
    pixel_t      got;
    pixel_t      want;
    hold_left = 0;
    held_once = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {pixel_x_o, pixel_y_o, red_o, green_o, blue_o, last_o};
        if (pixels_due.size() == 0) begin
          $display("%0t: pixel with none expected, got x=%0h y=%0h", $time, got.x, got.y);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x) report_field("pixel_x", want.x, got.x);
          if (got.y !== want.y) report_field("pixel_y", want.y, got.y);
          if (got.r !== want.r) report_field("red", want.r, got.r);
          if (got.g !== want.g) report_field("green", want.g, got.g);
          if (got.b !== want.b) report_field("blue", want.b, got.b);
          if (got.last !== want.last) report_field("last", want.last, got.last);
        end
      end
      // Hold off once for a long stretch so the block backs up into its input.
      if (!held_once && items_in >= 120) begin
        held_once = 1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (items_in >= 200 && items_in < 280) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin : stim
    stim_row_t   dir_rows [22];
    int unsigned pick;
    logic        c;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [23:0] col;
    logic [7:0]  ch;

    font_rom = '{
      30'h1DF6D, 30'h35F6F, 30'h1C927, 30'h35B6E, 30'h3CD27, 30'h1CD24,
      30'h1C96F, 30'h2DF6D, 30'h3A497, 30'h3924E, 30'h2DD6D, 30'h24927,
      30'h3D5AD6B1, 30'h35B6D, 30'h1DB6E, 30'h3DD24, 30'h1DB71, 30'h3DD6D,
      30'h1CE4E, 30'h3A492, 30'h2DB6F, 30'h2DB6A, 30'h235AD6AA, 30'h2D4AD,
      30'h2DA92, 30'h394A7, 30'h1DB6E, 30'h16497, 30'h312A7, 30'h31C4E,
      30'h2D649, 30'h3CC4E, 30'h1CD6B, 30'h39292, 30'h1D56E, 30'h35ACE
    };
    pen_x     = '0;
    pen_y     = '0;
    pen_color = '0;

    dir_rows = '{
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "A",   1'b0},  // drawn at reset pen
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, " ",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, 8'h00, 1'b1},
      '{CmdStart, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 8'h00, 1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "M",   1'b0},  // wraps in x and y
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "W",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "0",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "9",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "Z",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, 8'hFF, 1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "@",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "[",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "/",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, ":",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "a",   1'b1},
      '{CmdStart, 16'h0000, 16'h0000, 24'h000000, 8'h00, 1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "B",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, 8'h7F, 1'b1},
      '{CmdStart, 16'hFFFC, 16'h5AA5, 24'hA55A5A, 8'h00, 1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "W",   1'b0},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, " ",   1'b1},
      '{CmdChar,  16'h0000, 16'h0000, 24'h000000, "Q",   1'b0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].ox, dir_rows[i].oy, dir_rows[i].col,
                dir_rows[i].ch, dir_rows[i].quiet);
    end

    // Strings: a start now and then, mostly printable glyphs, some junk codes.
    for (int n = 0; n < 420; n++) begin
      ox  = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(31)) : 16'($urandom);
      oy  = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(7)) : 16'($urandom);
      col = 24'($urandom);
      c   = ($urandom_range(99) < 10) ? CmdStart : CmdChar;
      pick = $urandom_range(99);
      if (pick < 10) begin
        ch = $urandom_range(1) ? "M" : "W";
      end else if (pick < 60) begin
        ch = CharA + 8'($urandom_range(25));
      end else if (pick < 75) begin
        ch = Char0 + 8'($urandom_range(9));
      end else if (pick < 85) begin
        ch = CharSpace;
      end else begin
        ch = 8'($urandom_range(255));
      end
      send_item(c, ox, oy, col, ch, 1'b0);
    end
    in_valid_i <= 1'b0;

    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
